// ----- rtl/wac_pkg.sv -----
// Package with the shared constants, types and helper functions of the wheel angle conditioner.
`timescale 1ns / 1ps
package wac_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int COEF_FRAC_BITS_DEF  = 30;

   localparam longint Q30_B      = 64'sd21564350;
   localparam longint Q30_A0_MAG = 64'sd688645970;
   localparam longint Q30_A1     = 64'sd1676130396;

   localparam int PERCENT_BASE = 100;
   localparam int JUMP_DEGREES = 5;

   // floor(x / 100) is (x * PCT_RECIP) >> PCT_RECIP_SH for x below 2^32, and
   // (x * PCT_FRAC_RECIP) >> PCT_FRAC_SH for x below 43690.
   localparam longint PCT_RECIP      = 64'sd1374389535;
   localparam int     PCT_RECIP_SH   = 37;
   localparam int     PCT_FRAC_RECIP = 41944;
   localparam int     PCT_FRAC_SH    = 22;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_APPLY_ZERO    = 3'd0,
      CSR_ZERO_POSITION = 3'd1,
      CSR_COUNTS_PER_DEG = 3'd2,
      CSR_INVERT_SENSOR = 3'd3,
      CSR_ANGLE_OFFSET  = 3'd4,
      CSR_ACK_PERCENT   = 3'd5,
      CSR_ACK_ABOVE     = 3'd6
   } wac_csr_type;

   typedef struct packed {
      logic load_in;
      logic raw_take;
      logic inv;
      logic off;
      logic mul_rcp;
      logic quo_take;
      logic mul_pct;
      logic frac_take;
      logic pct_take;
      logic mul_b;
      logic mul_a0;
      logic mul_a1;
      logic acc_clr;
      logic acc_add;
      logic round;
      logic commit;
   } wac_cmd_type;

   typedef struct packed {
      logic div_busy;
   } wac_status_type;

   // Saturates a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] max_v;
      logic signed [67:0] min_v;
      max_v = 68'sh0_0000_0000_7FFF_FFFF;
      min_v = -68'sh0_0000_0000_8000_0000;
      if (v > max_v) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ----- rtl/wac_if.sv -----
// Valid/ready channel interfaces for the sensor word and the result word.
`timescale 1ns / 1ps
interface wac_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] raw_counts;
   logic               supply_pin_low;
   modport source (output valid, output raw_counts, output supply_pin_low, input ready);
   modport sink   (input valid, input raw_counts, input supply_pin_low, output ready);
endinterface

interface wac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] raw_angle;
   logic signed [31:0] filtered_angle;
   logic               plausibility_error;
   logic               plausibility_event;
   logic               supply_error;
   logic               supply_event;
   modport source (output valid, output raw_angle, output filtered_angle,
                   output plausibility_error, output plausibility_event,
                   output supply_error, output supply_event, input ready);
   modport sink   (input valid, input raw_angle, input filtered_angle,
                   input plausibility_error, input plausibility_event,
                   input supply_error, input supply_event, output ready);
endinterface

// ----- rtl/wac_ctrl.sv -----
// Controller state machine that sequences the divider, multiplier and filter steps.
`timescale 1ns / 1ps
module wac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  wac_pkg::wac_status_type status,
   output wac_pkg::wac_cmd_type    cmd
);
   import wac_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE = 16'b0000000000000001,
      ST_DIV  = 16'b0000000000000010,
      ST_RAW  = 16'b0000000000000100,
      ST_INV  = 16'b0000000000001000,
      ST_OFF  = 16'b0000000000010000,
      ST_RCP  = 16'b0000000000100000,
      ST_QUO  = 16'b0000000001000000,
      ST_PMUL = 16'b0000000010000000,
      ST_FRAC = 16'b0000000100000000,
      ST_PCT  = 16'b0000001000000000,
      ST_MB   = 16'b0000010000000000,
      ST_MA0  = 16'b0000100000000000,
      ST_MA1  = 16'b0001000000000000,
      ST_MACC = 16'b0010000000000000,
      ST_RND  = 16'b0100000000000000,
      ST_FIN  = 16'b1000000000000000
   } wac_state_type;

   wac_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            cmd.raw_take = 1'b1;
            state_in     = ST_INV;
         end
         ST_INV: begin
            cmd.inv  = 1'b1;
            state_in = ST_OFF;
         end
         ST_OFF: begin
            cmd.off  = 1'b1;
            state_in = ST_RCP;
         end
         ST_RCP: begin
            cmd.mul_rcp = 1'b1;
            state_in    = ST_QUO;
         end
         ST_QUO: begin
            cmd.quo_take = 1'b1;
            state_in     = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.mul_pct = 1'b1;
            state_in    = ST_FRAC;
         end
         ST_FRAC: begin
            cmd.frac_take = 1'b1;
            state_in      = ST_PCT;
         end
         ST_PCT: begin
            cmd.pct_take = 1'b1;
            state_in     = ST_MB;
         end
         ST_MB: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_MA0;
         end
         ST_MA0: begin
            cmd.mul_a0  = 1'b1;
            cmd.acc_clr = 1'b1;
            state_in    = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_a1  = 1'b1;
            cmd.acc_add = 1'b1;
            state_in    = ST_MACC;
         end
         ST_MACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_RND;
         end
         ST_RND: begin
            cmd.round = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/wac_datapath.sv -----
// Datapath with the configuration registers, divider, shared multiplier and filter state.
`timescale 1ns / 1ps
module wac_datapath #(
   parameter int ANGLE_FRAC_BITS = wac_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COEF_FRAC_BITS  = wac_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wac_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic signed [15:0]              in_raw_counts,
   input  logic                            in_supply_pin_low,
   input  wac_pkg::wac_cmd_type            cmd,
   output wac_pkg::wac_status_type         status,
   output logic signed [31:0]              out_raw_angle,
   output logic signed [31:0]              out_filtered_angle,
   output logic                            out_plaus_error,
   output logic                            out_plaus_event,
   output logic                            out_supply_error,
   output logic                            out_supply_event
);
   import wac_pkg::*;

   localparam int     DIV_W    = 25 + ANGLE_FRAC_BITS;
   localparam int     CNT_W    = $clog2(DIV_W + 1);
   localparam int     SH       = 8 + ANGLE_FRAC_BITS;
   localparam int     MW       = 33;
   localparam int     PW       = 2 * MW;
   localparam int     AW       = 68;
   localparam int     CSH      = 30 - COEF_FRAC_BITS;
   localparam longint CoefRnd  = (64'sd1 << CSH) >>> 1;
   localparam longint CoefB    = (Q30_B + CoefRnd) >>> CSH;
   localparam longint CoefA0   = -((Q30_A0_MAG + CoefRnd) >>> CSH);
   localparam longint CoefA1   = (Q30_A1 + CoefRnd) >>> CSH;
   localparam longint JumpLim  = longint'(JUMP_DEGREES) << ANGLE_FRAC_BITS;
   localparam longint RndHalf  = 64'sd1 << (COEF_FRAC_BITS - 1);

   // Configuration registers.
   logic               apply_zero_ff;
   logic signed [15:0] zero_pos_ff;
   logic [15:0]        cpd_ff;
   logic               invert_ff;
   logic signed [31:0] offset_ff;
   logic [7:0]         pct_ff;
   logic               ack_above_ff;

   // Working registers.
   logic               pin_low_ff;
   logic [DIV_W-1:0]   div_q_ff, div_q_in;
   logic [16:0]        div_rem_ff, div_rem_in;
   logic [15:0]        div_dvs_ff, div_dvs_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic               div_neg_ff, div_neg_in;
   logic signed [31:0] raw_ff;
   logic signed [31:0] a_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [31:0] n_ff;
   logic [24:0]        qa_ff;
   logic [6:0]         ra_ff;
   logic [14:0]        rp_ff;
   logic [7:0]         frac_ff;

   // Filter and flag state.
   logic signed [31:0] older_ff;
   logic signed [31:0] newer_ff;
   logic signed [31:0] last_ff;
   logic               jump_flag_ff;
   logic               supply_flag_ff;

   // Result register.
   logic signed [31:0] o_raw_ff, o_filt_ff;
   logic               o_perr_ff, o_pevt_ff, o_serr_ff, o_sevt_ff;

   logic signed [16:0] diff;
   logic [16:0]        diff_mag;
   logic [16:0]        rem_sh;
   logic               rem_ge;
   logic signed [31:0] quot;
   logic signed [MW-1:0] mul_x, mul_y;
   logic signed [AW-1:0] rnd;
   logic signed [AW-1:0] y_sum;
   logic signed [31:0] y;
   logic signed [33:0] jump;
   logic [33:0]        jump_mag;
   logic               jump_big;
   logic               scale_sel;
   logic [32:0]        a_mag;
   logic [24:0]        qa;
   logic [6:0]         ra;
   logic [30:0]        frac_prod;
   logic [32:0]        pct_sum;
   logic signed [AW-1:0] pct_pos;
   logic signed [AW-1:0] pct_val;

   assign status.div_busy = (div_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_zero_ff <= 1'b1;
         zero_pos_ff   <= '0;
         cpd_ff        <= 16'd256;
         invert_ff     <= 1'b0;
         offset_ff     <= '0;
         pct_ff        <= 8'(PERCENT_BASE);
         ack_above_ff  <= 1'b1;
      end else if (csr_we) begin
         case (wac_csr_type'(csr_index))
            CSR_APPLY_ZERO:     apply_zero_ff <= csr_wdata[0];
            CSR_ZERO_POSITION:  zero_pos_ff   <= csr_wdata[15:0];
            CSR_COUNTS_PER_DEG: cpd_ff        <= csr_wdata[15:0];
            CSR_INVERT_SENSOR:  invert_ff     <= csr_wdata[0];
            CSR_ANGLE_OFFSET:   offset_ff     <= csr_wdata[31:0];
            CSR_ACK_PERCENT:    pct_ff        <= csr_wdata[7:0];
            CSR_ACK_ABOVE:      ack_above_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      diff     = 17'(in_raw_counts) - (apply_zero_ff ? 17'(zero_pos_ff) : 17'sd0);
      diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
      rem_sh   = {div_rem_ff[15:0], div_q_ff[DIV_W-1]};
      rem_ge   = (rem_sh >= {1'b0, div_dvs_ff});

      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_dvs_in = div_dvs_ff;
      div_cnt_in = div_cnt_ff;
      div_neg_in = div_neg_ff;
      if (cmd.load_in) begin
         div_q_in   = DIV_W'(diff_mag) << SH;
         div_rem_in = '0;
         div_dvs_in = (cpd_ff == '0) ? 16'd1 : cpd_ff;
         div_cnt_in = CNT_W'(DIV_W);
         div_neg_in = diff[16];
      end else if (div_cnt_ff != '0) begin
         div_q_in   = {div_q_ff[DIV_W-2:0], rem_ge};
         div_rem_in = rem_ge ? rem_sh - {1'b0, div_dvs_ff} : rem_sh;
         div_cnt_in = div_cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      if (div_neg_ff) begin
         quot = (div_q_ff >= (DIV_W'(1) << 31)) ? 32'sh8000_0000 : -32'(div_q_ff);
      end else begin
         quot = (div_q_ff >= (DIV_W'(1) << 31)) ? 32'sh7FFF_FFFF : 32'(div_q_ff);
      end
   end

   // The percentage is split as |a| = 100 * qa + ra, so that
   // |a| * pct / 100 = qa * pct + (ra * pct) / 100 needs no wide reciprocal.
   always_comb begin
      a_mag     = a_ff[31] ? 33'(-(33'(a_ff))) : 33'(a_ff);
      qa        = prod_ff[PCT_RECIP_SH+24:PCT_RECIP_SH];
      ra        = 7'(a_mag - 33'(qa) * 33'(PERCENT_BASE));
      frac_prod = 31'(rp_ff) * 31'(PCT_FRAC_RECIP);
      pct_sum   = prod_ff[32:0] + 33'(frac_ff);
      pct_pos   = AW'({1'b0, pct_sum});
      pct_val   = a_ff[31] ? -pct_pos : pct_pos;
   end

   always_comb begin
      mul_x = MW'(a_ff);
      mul_y = MW'(CoefB);
      if (cmd.mul_rcp) begin
         mul_x = MW'(a_mag);
         mul_y = MW'(PCT_RECIP);
      end else if (cmd.mul_pct) begin
         mul_x = MW'(qa_ff);
         mul_y = MW'(pct_ff);
      end else if (cmd.mul_a0) begin
         mul_x = MW'(older_ff);
         mul_y = MW'(CoefA0);
      end else if (cmd.mul_a1) begin
         mul_x = MW'(newer_ff);
         mul_y = MW'(CoefA1);
      end
   end

   always_comb begin
      scale_sel = ((a_ff > 0) && ack_above_ff) || ((a_ff < 0) && !ack_above_ff);
      rnd       = (acc_ff + AW'(RndHalf)) >>> COEF_FRAC_BITS;
      y_sum     = AW'(older_ff) + AW'(n_ff) + (AW'(newer_ff) <<< 1);
      y         = sat32(y_sum);
      jump      = 34'(last_ff) - 34'(a_ff);
      jump_mag  = jump[33] ? 34'(-jump) : 34'(jump);
      jump_big  = (jump_mag > 34'(JumpLim));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff     <= '0;
         older_ff       <= '0;
         newer_ff       <= '0;
         last_ff        <= '0;
         jump_flag_ff   <= 1'b1;
         supply_flag_ff <= 1'b0;
      end else begin
         div_cnt_ff <= div_cnt_in;
         if (cmd.commit) begin
            older_ff       <= newer_ff;
            newer_ff       <= n_ff;
            last_ff        <= y;
            jump_flag_ff   <= jump_big;
            supply_flag_ff <= pin_low_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_dvs_ff <= div_dvs_in;
      div_neg_ff <= div_neg_in;
      if (cmd.load_in) begin
         pin_low_ff <= in_supply_pin_low;
      end
      if (cmd.raw_take) begin
         raw_ff <= quot;
      end
      if (cmd.inv) begin
         a_ff <= invert_ff ? sat32(-AW'(raw_ff)) : raw_ff;
      end else if (cmd.off) begin
         a_ff <= sat32(AW'(a_ff) - AW'(offset_ff));
      end else if (cmd.pct_take && scale_sel) begin
         a_ff <= sat32(pct_val);
      end
      if (cmd.quo_take) begin
         qa_ff <= qa;
         ra_ff <= ra;
      end
      if (cmd.mul_pct) begin
         rp_ff <= 15'(ra_ff) * 15'(pct_ff);
      end
      if (cmd.frac_take) begin
         frac_ff <= 8'(frac_prod >> PCT_FRAC_SH);
      end
      if (cmd.mul_rcp || cmd.mul_pct || cmd.mul_b || cmd.mul_a0 || cmd.mul_a1) begin
         prod_ff <= mul_x * mul_y;
      end
      if (cmd.acc_clr) begin
         acc_ff <= AW'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
      if (cmd.round) begin
         n_ff <= sat32(rnd);
      end
      if (cmd.commit) begin
         o_raw_ff  <= raw_ff;
         o_filt_ff <= y;
         o_perr_ff <= jump_big;
         o_pevt_ff <= jump_big && !jump_flag_ff;
         o_serr_ff <= pin_low_ff;
         o_sevt_ff <= pin_low_ff && !supply_flag_ff;
      end
   end

   assign out_raw_angle      = o_raw_ff;
   assign out_filtered_angle = o_filt_ff;
   assign out_plaus_error    = o_perr_ff;
   assign out_plaus_event    = o_pevt_ff;
   assign out_supply_error   = o_serr_ff;
   assign out_supply_event   = o_sevt_ff;

endmodule

// ----- rtl/wheel_angle_conditioner_core.sv -----
// Top level of the wheel angle conditioner: controller, datapath and channel ports.
`timescale 1ns / 1ps
// Takes one sensor word at a time and returns one result word per sensor word. Angles are
// in Q15.16 format at the default ANGLE_FRAC_BITS, and the next sensor word can be accepted
// as soon as the previous result word is presented. Most of the time of a word is spent in
// the one-bit-a-cycle divider for the count-to-degree scaling; the Ackermann percentage uses
// reciprocal multiplication in a few steps, followed by three passes through the shared
// multiplier for the filter. A finished word waits in the output register while the next
// sensor word is accepted; it only holds up the block when the next word is done.
module wheel_angle_conditioner_core #(
   parameter int ANGLE_FRAC_BITS = wac_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COEF_FRAC_BITS  = wac_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wac_req_if.sink                        req_chan,
   wac_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [wac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wac_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wac_pkg::*;

   wac_cmd_type    cmd;
   wac_status_type status;

   wac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wac_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .in_raw_counts      (req_chan.raw_counts),
      .in_supply_pin_low  (req_chan.supply_pin_low),
      .cmd                (cmd),
      .status             (status),
      .out_raw_angle      (rsp_chan.raw_angle),
      .out_filtered_angle (rsp_chan.filtered_angle),
      .out_plaus_error    (rsp_chan.plausibility_error),
      .out_plaus_event    (rsp_chan.plausibility_event),
      .out_supply_error   (rsp_chan.supply_error),
      .out_supply_event   (rsp_chan.supply_event)
   );

endmodule

// ----- rtl/wac_checker.sv -----
// Port-level checker for the wheel angle conditioner, with its bind to the top level.
`timescale 1ns / 1ps
module wac_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_filtered_angle,
   input logic               rsp_perr,
   input logic               rsp_pevt,
   input logic               rsp_serr,
   input logic               rsp_sevt
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_angle))
      else $error("result word dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sensor word accepted while the previous one is in work");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_pevt_has_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pevt || rsp_perr)
      else $error("plausibility event without plausibility error");

   a_sevt_has_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_sevt || rsp_serr)
      else $error("supply event without supply error");

endmodule

bind wheel_angle_conditioner_core wac_checker u_wac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_filtered_angle (rsp_chan.filtered_angle),
   .rsp_perr           (rsp_chan.plausibility_error),
   .rsp_pevt           (rsp_chan.plausibility_event),
   .rsp_serr           (rsp_chan.supply_error),
   .rsp_sevt           (rsp_chan.supply_event)
);

// ----- test/testbench.sv -----
// Self-checking testbench of the wheel angle conditioner: directed and random sensor words.
`timescale 1ns / 1ps
module testbench;
   import wac_pkg::*;

   typedef struct packed {
      logic signed [15:0] counts;
      logic               pin_low;
   } sensor_word_type;

   typedef struct packed {
      logic signed [31:0] raw;
      logic signed [31:0] filt;
      logic               p_err;
      logic               p_evt;
      logic               s_err;
      logic               s_evt;
   } angle_word_type;

   typedef struct {
      logic signed [15:0] counts;
      logic               pin_low;
      logic               has_exp;
      angle_word_type     exp;
   } stim_row_type;

   localparam longint COEF_B  = Q30_B;
   localparam longint COEF_A0 = -Q30_A0_MAG;
   localparam longint COEF_A1 = Q30_A1;
   localparam longint JUMP_LIM = longint'(JUMP_DEGREES) <<< 16;
   localparam longint CYCLE_LIMIT = 64'd1500000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wac_req_if req_chan ();
   wac_rsp_if rsp_chan ();

   wheel_angle_conditioner_core u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow configuration and conditioner state.
   logic        m_apply_zero;
   logic [15:0] m_zero;
   logic [15:0] m_cpd;
   logic        m_invert;
   logic [31:0] m_offset;
   logic [7:0]  m_pct;
   logic        m_above;
   longint      m_older, m_newer, m_last;
   logic        m_jump_flag, m_supply_flag;

   angle_word_type expected_words[$];
   int   errors;
   int   words_sent;
   int   words_checked;
   longint cycles;
   logic rsp_ready_en;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic shadow_reset();
      m_apply_zero = 1; m_zero = 0; m_cpd = 256; m_invert = 0; m_offset = 0;
      m_pct = 100; m_above = 1; m_older = 0; m_newer = 0; m_last = 0;
      m_jump_flag = 1; m_supply_flag = 0;
   endtask

   function automatic angle_word_type condition_angle(sensor_word_type w);
      angle_word_type r;
      longint d, cpd, raw, a, jmp, acc, n, y;
      d = longint'(w.counts);
      if (m_apply_zero) d = d - longint'($signed(m_zero));
      cpd = (m_cpd == 0) ? 1 : longint'(m_cpd);
      raw = clamp32((d <<< 24) / cpd);
      a = raw;
      if (m_invert) a = clamp32(-a);
      a = clamp32(a - longint'($signed(m_offset)));
      if ((a > 0 && m_above) || (a < 0 && !m_above)) a = clamp32(a * longint'(m_pct) / 100);
      r.s_evt = 0;
      if (w.pin_low) begin
         r.s_evt = !m_supply_flag;
         m_supply_flag = 1;
      end else begin
         m_supply_flag = 0;
      end
      jmp = m_last - a;
      if (jmp < 0) jmp = -jmp;
      r.p_evt = 0;
      if (jmp > JUMP_LIM) begin
         r.p_evt = !m_jump_flag;
         m_jump_flag = 1;
      end else begin
         m_jump_flag = 0;
      end
      acc = COEF_B * a + COEF_A0 * m_older + COEF_A1 * m_newer;
      n = clamp32((acc + (64'sd1 <<< 29)) >>> 30);
      y = clamp32(m_older + n + 2 * m_newer);
      m_older = m_newer;
      m_newer = n;
      m_last = y;
      r.raw = raw[31:0];
      r.filt = y[31:0];
      r.p_err = m_jump_flag;
      r.s_err = m_supply_flag;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: random stall per word once rsp_ready_en is set, compared with the oldest expectation.
   initial begin : rsp_side
      int stall;
      angle_word_type got, exp;
      rsp_chan.ready = 0;
      @(negedge reset);
      forever begin
         stall = rsp_ready_en ? $urandom_range(0, 19) : 0;
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_chan.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = '{rsp_chan.raw_angle, rsp_chan.filtered_angle, rsp_chan.plausibility_error,
                 rsp_chan.plausibility_event, rsp_chan.supply_error, rsp_chan.supply_event};
         if (expected_words.size() == 0) begin
            $display("%0t unexpected word %p", $time, got);
            errors++;
         end else begin
            exp = expected_words.pop_front();
            words_checked++;
            if (got !== exp) begin
               $display("%0t mismatch: expected %p actual %p", $time, exp, got);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(wac_csr_type idx, logic [31:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_APPLY_ZERO:     m_apply_zero = val[0];
         CSR_ZERO_POSITION:  m_zero = val[15:0];
         CSR_COUNTS_PER_DEG: m_cpd = val[15:0];
         CSR_INVERT_SENSOR:  m_invert = val[0];
         CSR_ANGLE_OFFSET:   m_offset = val;
         CSR_ACK_PERCENT:    m_pct = val[7:0];
         CSR_ACK_ABOVE:      m_above = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Valid stays high after an accept until the next word or a drain replaces it; the block
   // is busy after an accept until its result word is committed, so the old word is never taken twice.
   task automatic send_word(sensor_word_type w, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.raw_counts <= w.counts;
      req_chan.supply_pin_low <= w.pin_low;
      do @(posedge clock); while (!req_chan.ready);
      expected_words.push_back(condition_angle(w));
      words_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      sensor_word_type w;
      int mode;
      bit gaps;
      gaps = $urandom_range(0, 1);
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) w.counts = $signed(m_zero) + $signed(16'($urandom_range(0, 800))) - 400;
         else w.counts = $urandom;
         w.pin_low = ($urandom_range(0, 5) == 0);
         if (i % 50 == 0) gaps = $urandom_range(0, 2) != 0;
         send_word(w, gaps);
      end
      drain();
   endtask

   stim_row_type rows[] = '{
      '{16'sd0,      1'b0, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{16'sd0,      1'b1, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{16'sd0,      1'b1, 1'b0, '{default: '0}},
      '{16'sd32767,  1'b0, 1'b0, '{default: '0}},
      '{16'sd32767,  1'b0, 1'b0, '{default: '0}},
      '{-16'sd32768, 1'b1, 1'b0, '{default: '0}},
      '{16'sd100,    1'b0, 1'b0, '{default: '0}},
      '{-16'sd1,     1'b0, 1'b0, '{default: '0}},
      '{16'sd1,      1'b1, 1'b0, '{default: '0}},
      '{16'sd21845,  1'b0, 1'b0, '{default: '0}},
      '{-16'sd21846, 1'b0, 1'b0, '{default: '0}}
   };

   initial begin : stimulus
      sensor_word_type w;
      angle_word_type pred;
      errors = 0; words_sent = 0; words_checked = 0; cycles = 0; rsp_ready_en = 0;
      reset <= 1; csr_we <= 0; csr_index <= '0; csr_wdata <= '0;
      req_chan.valid <= 0; req_chan.raw_counts <= '0; req_chan.supply_pin_low <= 0;
      shadow_reset();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         w = '{rows[i].counts, rows[i].pin_low};
         if (rows[i].has_exp) begin
            pred = condition_angle(w);
            m_older = 0; m_newer = 0; m_last = 0;
            shadow_reset();
            if (i == 1) m_jump_flag = 0;
            if (pred !== rows[i].exp)
               $display("%0t table row %0d disagrees with prediction", $time, i);
         end
         send_word(w, 1'b0);
         if (rows[i].has_exp) begin
            expected_words.pop_back();
            expected_words.push_back(rows[i].exp);
            if (i == 0) begin
               m_jump_flag = 0;
            end else begin
               m_jump_flag = 0; m_supply_flag = 1;
            end
         end
      end
      drain();

      // Extremes of the configuration, then random settings.
      csr_write(CSR_COUNTS_PER_DEG, 32'd0);
      csr_write(CSR_INVERT_SENSOR, 32'd1);
      csr_write(CSR_ANGLE_OFFSET, 32'h8000_0000);
      csr_write(CSR_ACK_PERCENT, 32'd255);
      csr_write(CSR_ACK_ABOVE, 32'd0);
      csr_write(CSR_ZERO_POSITION, 32'h0000_8000);
      for (int i = 0; i < 8; i++) begin
         w.counts = (i % 2) ? 16'sh7FFF : -16'sh8000;
         w.pin_low = i[1];
         send_word(w, 1'b0);
      end
      drain();
      csr_write(CSR_APPLY_ZERO, 32'd0);
      csr_write(CSR_COUNTS_PER_DEG, 32'hFFFF);
      csr_write(CSR_ANGLE_OFFSET, 32'h7FFF_FFFF);
      csr_write(CSR_ACK_PERCENT, 32'd0);
      random_phase(20);

      rsp_ready_en = 1;
      csr_write(CSR_APPLY_ZERO, 32'd1);
      csr_write(CSR_ZERO_POSITION, 32'd0);
      csr_write(CSR_COUNTS_PER_DEG, 32'd256);
      csr_write(CSR_INVERT_SENSOR, 32'd0);
      csr_write(CSR_ANGLE_OFFSET, 32'd0);
      csr_write(CSR_ACK_PERCENT, 32'd100);
      csr_write(CSR_ACK_ABOVE, 32'd1);
      random_phase(300);
      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_APPLY_ZERO, $urandom_range(0, 1));
         csr_write(CSR_ZERO_POSITION, $urandom);
         csr_write(CSR_COUNTS_PER_DEG, ($urandom_range(0, 3) == 0) ? $urandom
                   : $urandom_range(16, 1024));
         csr_write(CSR_INVERT_SENSOR, $urandom_range(0, 1));
         csr_write(CSR_ANGLE_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom
                   : $signed($urandom_range(0, 20 << 16)) - (10 << 16));
         csr_write(CSR_ACK_PERCENT, $urandom_range(0, 255));
         csr_write(CSR_ACK_ABOVE, $urandom_range(0, 1));
         random_phase(240);
      end

      $display("Sent %0d sensor words over several register settings; %0d results checked.",
               words_sent, words_checked);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Errors: %0d, results outstanding: %0d", errors, expected_words.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
